// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lcgskip_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgskip_pkg
// Types and constants of the gated Lehmer generator.
// ----------------------------------------------------------------------------
package lcgskip_pkg;

   localparam int STATE_W = 31;
   localparam int SKIP_W  = 16;
   localparam int COUNT_W = 7;
   localparam int VALUE_W = 16;
   localparam int PROD_W  = 46;
   localparam int MULT_W  = 15;

   localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'h41A7;
   localparam logic [STATE_W:0]   LEHMER_MOD  = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VALUE_ALIAS = 16'h8000;
   localparam logic [STATE_W-1:0] SEED_RESET  = 31'd1;

   // configuration register indexes
   localparam logic CSR_SEED = 1'b0;
   localparam logic CSR_SKIP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED
   } state_type;

endpackage

// ----- rtl/lcgskip_mulmod.sv -----
// ----------------------------------------------------------------------------
// lcgskip_mulmod
// Shared multiply unit: registered s*16807, then fold mod 2^31-1.
// ----------------------------------------------------------------------------
module lcgskip_mulmod (
   input  logic                             clock,
   input  logic                             mul_en,
   input  logic [lcgskip_pkg::STATE_W-1:0]  operand,
   output logic [lcgskip_pkg::STATE_W-1:0]  result
);

   logic [lcgskip_pkg::PROD_W-1:0]  product_ff;
   logic [lcgskip_pkg::PROD_W-1:0]  product_in;
   logic [lcgskip_pkg::STATE_W:0]   fold_sum;

   assign product_in = lcgskip_pkg::PROD_W'(operand)
                     * lcgskip_pkg::PROD_W'(lcgskip_pkg::LEHMER_MULT);

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   // 2^31 == 1 mod M, so high part adds onto low part; one subtract finishes
   assign fold_sum = {1'b0, product_ff[lcgskip_pkg::STATE_W-1:0]}
                   + (lcgskip_pkg::STATE_W+1)'(product_ff[lcgskip_pkg::PROD_W-1:
                                                          lcgskip_pkg::STATE_W]);

   always_comb begin
      if (fold_sum >= lcgskip_pkg::LEHMER_MOD) begin
         result = lcgskip_pkg::STATE_W'(fold_sum - lcgskip_pkg::LEHMER_MOD);
      end else begin
         result = fold_sum[lcgskip_pkg::STATE_W-1:0];
      end
   end

endmodule

// ----- rtl/lcg_16807_with_skip_gating.sv -----
// ----------------------------------------------------------------------------
// lcg_16807_with_skip_gating
// Minimal standard Lehmer generator with alternating keep/discard runs.
// ----------------------------------------------------------------------------
// First value: the product is registered in ST_MUL, then folded and loaded into
//   the output register in ST_RED once that register has room.
// Each generator step passes ST_MUL then ST_RED through the one shared multiplier;
//   a new request is taken only in ST_IDLE, after the whole batch is done.
// Ready again in the cycle after the last value is loaded into the output register.
// Reset (synchronous): seed 1, skip_len 0, state 1, keep phase, no output.
module lcg_16807_with_skip_gating #(
   parameter int MAX_BATCH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] count, [7] zero fill
   input  logic        req_tuser,   // [0] restart
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] value
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   localparam logic [lcgskip_pkg::COUNT_W-1:0] MaxBatch =
      lcgskip_pkg::COUNT_W'(MAX_BATCH);
   localparam logic [lcgskip_pkg::COUNT_W-1:0] CountOne =
      lcgskip_pkg::COUNT_W'(1);
   localparam logic [lcgskip_pkg::SKIP_W-1:0]  PosOne =
      lcgskip_pkg::SKIP_W'(1);

   lcgskip_pkg::state_type state_ff, state_in;

   logic [lcgskip_pkg::STATE_W-1:0] seed_ff;
   logic [lcgskip_pkg::SKIP_W-1:0]  skip_len_ff;
   logic [lcgskip_pkg::STATE_W-1:0] gen_state_ff;
   logic [lcgskip_pkg::SKIP_W-1:0]  run_pos_ff;
   logic                            discarding_ff;
   logic [lcgskip_pkg::COUNT_W-1:0] remaining_ff;
   logic                            rsp_valid_ff;
   logic [lcgskip_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                            rsp_last_ff;

   logic [lcgskip_pkg::COUNT_W-1:0] want;
   logic [lcgskip_pkg::STATE_W-1:0] next_state;
   logic [lcgskip_pkg::SKIP_W-1:0]  pos_inc;
   logic [lcgskip_pkg::VALUE_W-1:0] value_out;
   logic                            req_fire;
   logic                            keep;
   logic                            out_free;
   logic                            run_end;
   logic                            mul_en;
   logic                            step_fire;

   // ---------------------------------------------------------------------
   // Shared multiply/fold unit: loaded in ST_MUL, result used in ST_RED
   // ---------------------------------------------------------------------
   lcgskip_mulmod u_mulmod (
      .clock   (clock),
      .mul_en  (mul_en),
      .operand (gen_state_ff),
      .result  (next_state)
   );

   // requested count saturates at the batch limit
   assign want = (req_tdata[lcgskip_pkg::COUNT_W-1:0] > MaxBatch)
               ? MaxBatch : req_tdata[lcgskip_pkg::COUNT_W-1:0];

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign keep     = (skip_len_ff == '0) || !discarding_ff;

   // run bookkeeping; a lowered skip_len ends the run at the next step
   assign pos_inc = run_pos_ff + PosOne;
   assign run_end = (pos_inc >= skip_len_ff) || (pos_inc == '0);

   assign value_out = (next_state[lcgskip_pkg::VALUE_W-1:0] == lcgskip_pkg::VALUE_ALIAS)
                    ? '0 : next_state[lcgskip_pkg::VALUE_W-1:0];

   // ---------------------------------------------------------------------
   // Sequencer outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      mul_en     = 1'b0;
      step_fire  = 1'b0;
      case (state_ff)
         lcgskip_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         lcgskip_pkg::ST_MUL: begin
            mul_en = 1'b1;
         end
         lcgskip_pkg::ST_RED: begin
            // a kept step waits for room in the output register
            step_fire = !keep || out_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcgskip_pkg::ST_IDLE: begin
            if (req_fire && (want != '0)) begin
               state_in = lcgskip_pkg::ST_MUL;
            end
         end
         lcgskip_pkg::ST_MUL: begin
            state_in = lcgskip_pkg::ST_RED;
         end
         lcgskip_pkg::ST_RED: begin
            if (step_fire) begin
               if (keep && (remaining_ff == CountOne)) begin
                  state_in = lcgskip_pkg::ST_IDLE;
               end else begin
                  state_in = lcgskip_pkg::ST_MUL;
               end
            end
         end
         default: begin
            state_in = lcgskip_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control and generator state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcgskip_pkg::ST_IDLE;
         seed_ff       <= lcgskip_pkg::SEED_RESET;
         skip_len_ff   <= '0;
         gen_state_ff  <= lcgskip_pkg::SEED_RESET;
         run_pos_ff    <= '0;
         discarding_ff <= 1'b0;
         remaining_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               lcgskip_pkg::CSR_SEED: seed_ff     <= csr_wdata;
               lcgskip_pkg::CSR_SKIP: skip_len_ff <= csr_wdata[lcgskip_pkg::SKIP_W-1:0];
               default: begin
               end
            endcase
         end

         if (req_fire) begin
            remaining_ff <= want;
            if (req_tuser) begin
               gen_state_ff  <= seed_ff;
               run_pos_ff    <= '0;
               discarding_ff <= 1'b0;
            end
         end

         if (step_fire) begin
            gen_state_ff <= next_state;
            if (skip_len_ff != '0) begin
               if (run_end) begin
                  run_pos_ff    <= '0;
                  discarding_ff <= !discarding_ff;
               end else begin
                  run_pos_ff <= pos_inc;
               end
            end
            if (keep) begin
               remaining_ff <= remaining_ff - CountOne;
            end
         end

         if (step_fire && keep) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (step_fire && keep) begin
         rsp_value_ff <= value_out;
         rsp_last_ff  <= (remaining_ff == CountOne);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/lcgskip_checker.sv -----
// ----------------------------------------------------------------------------
// lcgskip_checker
// Port-level checks on the gated Lehmer generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcgskip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled item holds its payload
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed while stalled")

   // a request with a nonzero count keeps the block busy
   `ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready && (req_tdata[6:0] != 7'd0), !req_tready, "ready stayed high after a batch request")

   // the aliased value never leaves the block
   `ASSERT_IMPL(a_no_alias, rsp_tvalid, rsp_tdata != 16'h8000, "value 0x8000 emitted")

   // a zero-count request produces no item
   `ASSERT_NEXT(a_zero_count_idle, req_tvalid && req_tready && (req_tdata[6:0] == 7'd0) && !rsp_tvalid, !rsp_tvalid && req_tready, "zero-count request produced output")

endmodule

bind lcg_16807_with_skip_gating lcgskip_checker u_lcgskip_checker (.*);

// ----- verif/lcg_16807_with_skip_gating_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_16807_with_skip_gating_tb
// Self-checking bench for the gated Lehmer generator. A directed table covers
// the count extremes, the seed corner values and skip run changes, then a run
// of random batches under random register settings. Each accepted request is
// expanded by a shadow generator into the values it must return. Every
// returned item is compared against that queue.
// ----------------------------------------------------------------------------
module lcg_16807_with_skip_gating_tb;

   localparam int MAX_BATCH       = 64;
   localparam int CYCLE_LIMIT     = 2_000_000;  // slowest legal run is far below this
   localparam int IDLE_SETTLE     = 8;          // a count-0 request may still be in flight
   localparam int TAIL_CYCLES     = 16;
   localparam int N_PHASES        = 9;
   localparam int ITEMS_PER_PHASE = 24;

   localparam int STATE_W = lcgskip_pkg::STATE_W;
   localparam int SKIP_W  = lcgskip_pkg::SKIP_W;
   localparam int COUNT_W = lcgskip_pkg::COUNT_W;
   localparam int VALUE_W = lcgskip_pkg::VALUE_W;

   // Seed whose first step lands exactly on 0x8000: 0x8000 times the inverse
   // of 16807 modulo 2^31-1, so the aliased value must come out as zero.
   localparam logic [63:0] ALIAS_WIDE = (64'd32768 * 64'd1407677000) % 64'h7FFF_FFFF;
   localparam logic [STATE_W-1:0] SEED_ALIAS = ALIAS_WIDE[STATE_W-1:0];

   // one generated value as it should appear on the response side
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } gen_value_type;

   // directed stimulus row; first_value is only meaningful when typed is set
   typedef struct packed {
      bit                 wr_seed;
      logic [STATE_W-1:0] seed;
      bit                 wr_skip;
      logic [SKIP_W-1:0]  skip;
      logic [COUNT_W-1:0] count;
      bit                 restart;
      bit                 typed;
      logic [VALUE_W-1:0] first_value;
   } directed_row_type;

   localparam int N_DIRECTED = 18;

   // DUT signals; the inputs are driven from time zero
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;   // [6:0] count, [7] zero fill
   logic                req_tuser  = 1'b0; // [0] restart
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;         // [15:0] value
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   logic                csr_index  = lcgskip_pkg::CSR_SEED;
   logic [30:0]         csr_wdata  = '0;

   // shadow copy of the generator and its registers
   logic [STATE_W-1:0]  seed_shadow;
   logic [SKIP_W-1:0]   skip_shadow;
   logic [STATE_W-1:0]  gen_shadow;
   logic [SKIP_W-1:0]   run_pos_shadow;
   bit                  discarding_shadow;

   gen_value_type       expected_values[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   bit                  stalls_on   = 1'b1;
   int                  stall_left  = 0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      // first step out of reset: state 1 -> 16807
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd1, 1'b0, 1'b1, 16'h41A7},
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd64, 1'b0, 1'b0, 16'h0000},
      // count above the batch limit saturates
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd127, 1'b0, 1'b0, 16'h0000},
      // zero count: restart only, nothing returned
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd0, 1'b1, 1'b0, 16'h0000},
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd1, 1'b0, 1'b1, 16'h41A7},
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd65, 1'b0, 1'b0, 16'h0000},
      // all-ones seed is congruent to zero
      '{1'b1, 31'h7FFF_FFFF, 1'b0, 16'd0, 7'd3, 1'b1, 1'b1, 16'h0000},
      // zero seed stays zero
      '{1'b1, 31'd0, 1'b0, 16'd0, 7'd2, 1'b1, 1'b1, 16'h0000},
      // first step hits 0x8000, reported as zero
      '{1'b1, SEED_ALIAS, 1'b0, 16'd0, 7'd1, 1'b1, 1'b1, 16'h0000},
      '{1'b1, 31'h7FFF_FFFE, 1'b0, 16'd0, 7'd5, 1'b1, 1'b0, 16'h0000},
      // keep/discard runs from the shortest up to the longest
      '{1'b1, 31'd1, 1'b1, 16'd1, 7'd8, 1'b1, 1'b1, 16'h41A7},
      '{1'b0, 31'd0, 1'b1, 16'd3, 7'd10, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 31'd0, 1'b1, 16'hFFFF, 7'd64, 1'b1, 1'b0, 16'h0000},
      // skip lowered below the current run position
      '{1'b0, 31'd0, 1'b1, 16'd2, 7'd5, 1'b0, 1'b0, 16'h0000},
      // skipping off: phase frozen, then resumed
      '{1'b0, 31'd0, 1'b1, 16'd0, 7'd4, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 31'd0, 1'b1, 16'd5, 7'd20, 1'b0, 1'b0, 16'h0000},
      '{1'b0, 31'd0, 1'b0, 16'd0, 7'd0, 1'b0, 1'b0, 16'h0000},
      '{1'b1, 31'h2A5A_C3E1, 1'b0, 16'd0, 7'd127, 1'b1, 1'b0, 16'h0000}
   };

   lcg_16807_with_skip_gating #(
      .MAX_BATCH (MAX_BATCH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Expand one accepted request into the values it must produce. The shadow
   // state advances exactly as the generator does: one step per iteration,
   // kept steps emit, discarded ones only move the run counter.
   task automatic expand_batch(input logic [COUNT_W-1:0] count, input bit restart,
                               input bit typed, input logic [VALUE_W-1:0] typed_first);
      int            want;
      int            done;
      bit            keep;
      logic [63:0]   product;
      gen_value_type entry;
      if (restart) begin
         gen_shadow        = seed_shadow;
         run_pos_shadow    = '0;
         discarding_shadow = 1'b0;
      end
      want = (count > MAX_BATCH) ? MAX_BATCH : int'(count);
      done = 0;
      while (done < want) begin
         keep       = (skip_shadow == '0) || !discarding_shadow;
         product    = 64'(gen_shadow) * 64'(lcgskip_pkg::LEHMER_MULT);
         gen_shadow = STATE_W'(product % 64'(lcgskip_pkg::LEHMER_MOD));
         if (keep) begin
            entry.value = gen_shadow[VALUE_W-1:0];
            if (entry.value == lcgskip_pkg::VALUE_ALIAS) begin
               entry.value = '0;
            end
            // hand-typed expectation replaces the computed one
            if (typed && done == 0) begin
               entry.value = typed_first;
            end
            entry.last = (done + 1 == want);
            expected_values.push_back(entry);
            done++;
         end
         // zero skip length freezes the run counter and phase
         if (skip_shadow != '0) begin
            run_pos_shadow = run_pos_shadow + 16'd1;
            if (run_pos_shadow >= skip_shadow || run_pos_shadow == '0) begin
               run_pos_shadow    = '0;
               discarding_shadow = !discarding_shadow;
            end
         end
      end
   endtask

   // Offer one request; valid stays high from the previous item unless a gap
   // is inserted. Expectations are queued at the accepting edge.
   task automatic send_req(input logic [COUNT_W-1:0] count, input bit restart,
                           input bit typed, input logic [VALUE_W-1:0] typed_first);
      @(negedge clock);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, count};
      req_tuser  = restart;
      do @(posedge clock); while (!req_tready);
      expand_batch(count, restart, typed, typed_first);
   endtask

   // Registers only change with the generator idle: all values back, plus an
   // IDLE_SETTLE wait for a request that returns nothing.
   task automatic settle_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [30:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      if (index == lcgskip_pkg::CSR_SEED) begin
         seed_shadow = data;
      end else begin
         skip_shadow = data[SKIP_W-1:0];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Response backpressure: random bursts with tready held low.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Compare every returned item with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      gen_value_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_values.size() == 0) begin
            $error("unexpected item: value %h last %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            head = expected_values.pop_front();
            if (rsp_tdata !== head.value) begin
               $error("value: expected %h actual %h", head.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== head.last) begin
               $error("last: expected %b actual %b", head.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      logic [STATE_W-1:0] seed;
      logic [SKIP_W-1:0]  skip;
      logic [COUNT_W-1:0] count;
      bit                 restart;
      bit                 big_skip;
      int                 sel;

      // reset values of the registers and generator
      seed_shadow       = lcgskip_pkg::SEED_RESET;
      skip_shadow       = '0;
      gen_shadow        = lcgskip_pkg::SEED_RESET;
      run_pos_shadow    = '0;
      discarding_shadow = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].wr_seed || directed_rows[r].wr_skip) begin
            settle_idle();
            if (directed_rows[r].wr_seed) begin
               write_csr(lcgskip_pkg::CSR_SEED, directed_rows[r].seed);
            end
            if (directed_rows[r].wr_skip) begin
               write_csr(lcgskip_pkg::CSR_SKIP, {15'd0, directed_rows[r].skip});
            end
         end
         send_req(directed_rows[r].count, directed_rows[r].restart,
                  directed_rows[r].typed, directed_rows[r].first_value);
      end

      // random phases, each under its own register setting
      for (int p = 0; p < N_PHASES; p++) begin
         settle_idle();
         // some phases run clean; the final one never stalls
         stalls_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);

         sel = $urandom_range(0, 9);
         case (sel)
            0:       seed = '0;
            1:       seed = 31'h7FFF_FFFF;
            2:       seed = 31'h7FFF_FFFE;
            default: seed = STATE_W'($urandom());
         endcase
         sel      = $urandom_range(0, 7);
         big_skip = 1'b0;
         case (sel)
            0: skip = '0;
            1: begin
               skip     = ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                                      : SKIP_W'($urandom_range(256, 65535));
               big_skip = 1'b1;
            end
            default: skip = SKIP_W'($urandom_range(1, 8));
         endcase
         write_csr(lcgskip_pkg::CSR_SEED, seed);
         write_csr(lcgskip_pkg::CSR_SKIP, {15'd0, skip});

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
               count = '0;
            end else if (sel <= 2) begin
               count = COUNT_W'($urandom_range(65, 127));
            end else if (sel <= 4) begin
               count = COUNT_W'($urandom_range(17, 64));
            end else begin
               count = COUNT_W'($urandom_range(1, 16));
            end
            // long runs start from a fresh phase so no huge discard run is owed
            restart = (i == 0 && (big_skip || $urandom_range(0, 1) == 0))
                      || ($urandom_range(0, 7) == 0);
            send_req(count, restart, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
